// ===== src/phcc_pkg.sv =====
`default_nettype none
package phcc_pkg;

  localparam int unsigned CFG_W = 30;
  localparam int unsigned EPS_W = 20;
  localparam int unsigned Z_W = 30;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GANTRY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_CLR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_HGT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd4;

  localparam logic [CFG_W-1:0] RADIUS_RST = 30'd45000000;
  localparam logic [CFG_W-1:0] GANTRY_RST = 30'd20000000;
  localparam logic [CFG_W-1:0] NEAR_CLR_RST = 30'd5000000;
  localparam logic [CFG_W-1:0] NEAR_HGT_RST = 30'd1000000;
  localparam logic [EPS_W-1:0] EPSILON_RST = 20'd100;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] radius;
    logic [CFG_W-1:0] gantry;
    logic [CFG_W-1:0] near_clr;
    logic [CFG_W-1:0] near_hgt;
    logic [EPS_W-1:0] epsilon;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/phcc_front.sv =====
`default_nettype none
module phcc_front import phcc_pkg::*; #(
  parameter int unsigned ITEM_W = 159
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ITEM_W-1:0] item_i,
  output logic                   busy_o,
  output logic                   item_valid_o,
  output logic [ITEM_W-1:0]      item_o,
  input  wire logic              item_pop_i
);

  // two-entry queue between command port and scan engine
  logic [ITEM_W-1:0] buf_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  assign busy_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_ptr_q];
  assign push         = start_i && !busy_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/phcc_back.sv =====
`default_nettype none
module phcc_back import phcc_pkg::*; #(
  parameter int unsigned MAX_ISLANDS = 256,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             item_valid_i,
  input  wire logic [4*COORD_BITS+Z_W:0]        item_i,
  output logic                                  item_pop_o,
  input  wire cfg_t                             cfg_i,
  output logic                                  done_o,
  output logic                                  plan_clear_o,
  output logic                                  hit_o,
  output logic                                  full_res_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned ENT_W = 4 * CB + Z_W;
  localparam int unsigned ADDR_W = $clog2(MAX_ISLANDS);
  localparam int unsigned CNT_W = $clog2(MAX_ISLANDS + 1);
  localparam int unsigned SW = ((CB > 31) ? CB : 31) + 1;
  localparam int unsigned OFS_MAXY = Z_W;
  localparam int unsigned OFS_MINY = Z_W + CB;
  localparam int unsigned OFS_MAXX = Z_W + 2 * CB;
  localparam int unsigned OFS_MINX = Z_W + 3 * CB;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ISLANDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  function automatic logic signed [SW-1:0] sx(input logic [CB-1:0] v);
    return $signed({{(SW-CB){v[CB-1]}}, v});
  endfunction

  // a_hi + c >= b_lo and b_hi + c >= a_lo
  function automatic logic spans(input logic [CB-1:0] a_lo, input logic [CB-1:0] a_hi,
                                 input logic [CB-1:0] b_lo, input logic [CB-1:0] b_hi,
                                 input logic [CFG_W-1:0] c);
    logic signed [SW-1:0] cs;
    cs = $signed({{(SW-CFG_W){1'b0}}, c});
    return ((sx(a_hi) + cs) >= sx(b_lo)) && ((sx(b_hi) + cs) >= sx(a_lo));
  endfunction

  logic [1:0]       state_q;
  logic [CNT_W-1:0] count_q;
  logic             failed_q;
  logic [CNT_W-1:0] idx_q;
  logic [ENT_W-1:0] cur_q;
  logic             hit_q;

  logic [ENT_W-1:0] mem_q [MAX_ISLANDS];
  logic [ENT_W-1:0] rd_data_q;
  logic             rd_v_q;

  logic             s1_v_q;
  logic [CFG_W-1:0] s1_c_q;
  logic             s1_skip_q;
  logic             s1_gantry_q;
  logic [ENT_W-1:0] s1_ent_q;

  logic done_q, clear_q, hitr_q, full_q;

  logic signed [Z_W:0] dz;
  logic                dz_skip, dz_near, dz_gantry;
  logic                y_ok, x_ok, pair_hit;
  logic                drained, is_full, mem_we, fail_now;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign drained    = !rd_v_q && !s1_v_q;
  assign is_full    = (count_q == CNT_MAX);
  assign mem_we     = (state_q == ST_DRAIN) && drained && !is_full;
  assign fail_now   = failed_q || hit_q || is_full;

  // stage 1: height classification of the stored entry
  always_comb begin
    dz = $signed({1'b0, rd_data_q[Z_W-1:0]}) - $signed({1'b0, cur_q[Z_W-1:0]});
    dz_skip   = dz <= $signed({{(Z_W+1-EPS_W){1'b0}}, cfg_i.epsilon});
    dz_near   = dz < $signed({1'b0, cfg_i.near_hgt});
    dz_gantry = dz >= $signed({1'b0, cfg_i.gantry});
  end

  // stage 2: footprint overlap with the selected clearance
  always_comb begin
    y_ok = spans(cur_q[OFS_MINY +: CB], cur_q[OFS_MAXY +: CB],
                 s1_ent_q[OFS_MINY +: CB], s1_ent_q[OFS_MAXY +: CB], s1_c_q);
    x_ok = spans(cur_q[OFS_MINX +: CB], cur_q[OFS_MAXX +: CB],
                 s1_ent_q[OFS_MINX +: CB], s1_ent_q[OFS_MAXX +: CB], s1_c_q);
    pair_hit = s1_v_q && !s1_skip_q && y_ok && (s1_gantry_q || x_ok);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[ADDR_W-1:0]] <= cur_q;
    end
    rd_data_q <= mem_q[idx_q[ADDR_W-1:0]];
    s1_c_q      <= dz_near ? cfg_i.near_clr : cfg_i.radius;
    s1_skip_q   <= dz_skip;
    s1_gantry_q <= dz_gantry;
    s1_ent_q    <= rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      failed_q <= 1'b0;
      idx_q    <= '0;
      cur_q    <= '0;
      hit_q    <= 1'b0;
      rd_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      done_q   <= 1'b0;
      clear_q  <= 1'b0;
      hitr_q   <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      rd_v_q <= (state_q == ST_SCAN) && (idx_q < count_q);
      s1_v_q <= rd_v_q;
      if (pair_hit) begin
        hit_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (item_i[ENT_W] == OP_CLEAR) begin
              count_q  <= '0;
              failed_q <= 1'b0;
              done_q   <= 1'b1;
              clear_q  <= 1'b1;
              hitr_q   <= 1'b0;
              full_q   <= 1'b0;
            end else begin
              cur_q   <= item_i[ENT_W-1:0];
              hit_q   <= 1'b0;
              idx_q   <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx_q < count_q) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            if (!is_full) begin
              count_q <= count_q + 1'b1;
            end
            failed_q <= fail_now;
            clear_q  <= !fail_now;
            hitr_q   <= hit_q;
            full_q   <= is_full;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign plan_clear_o = clear_q;
  assign hit_o        = hitr_q;
  assign full_res_o   = full_q;

endmodule
`default_nettype wire

// ===== src/print_head_collision_check.sv =====
// Print head collision check.
// Command port: raise start_i with opcode_i and the island fields; the command is
// taken at a clock edge where start_i is high and busy_o is low. Opcode clear
// starts a new plan; opcode add checks an island against all islands stored
// so far and then appends it if the store has room.
// A two-entry command queue feeds the scan engine, so busy_o only rises when
// two commands are waiting behind the one in progress.
// Results: done_o is high for exactly one cycle with plan_clear_o, hit_o and
// full_res_o valid in that cycle. The receiver cannot stall; results are
// never held back.
// The scan reads one stored island per cycle from the single-port island memory
// through a two-stage compare pipeline.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (0 radius, 1 gantry height, 2 near clearance, 3 near height, 4 epsilon).
// Write only while idle. Reset restores default registers and empties the plan.
`default_nettype none
module print_head_collision_check import phcc_pkg::*; #(
  parameter int unsigned MAX_ISLANDS = 256,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  opcode_i,
  input  wire logic [COORD_BITS-1:0] min_x_i,
  input  wire logic [COORD_BITS-1:0] max_x_i,
  input  wire logic [COORD_BITS-1:0] min_y_i,
  input  wire logic [COORD_BITS-1:0] max_y_i,
  input  wire logic [Z_W-1:0]        print_z_i,
  output logic                       done_o,
  output logic                       plan_clear_o,
  output logic                       hit_o,
  output logic                       full_res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned ITEM_W = 4 * COORD_BITS + Z_W + 1;

  cfg_t              cfg_q;
  logic [ITEM_W-1:0] cmd_item;
  logic [ITEM_W-1:0] q_item;
  logic              q_valid;
  logic              q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius   <= RADIUS_RST;
      cfg_q.gantry   <= GANTRY_RST;
      cfg_q.near_clr <= NEAR_CLR_RST;
      cfg_q.near_hgt <= NEAR_HGT_RST;
      cfg_q.epsilon  <= EPSILON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i;
        REG_GANTRY:   cfg_q.gantry   <= cfg_data_i;
        REG_NEAR_CLR: cfg_q.near_clr <= cfg_data_i;
        REG_NEAR_HGT: cfg_q.near_hgt <= cfg_data_i;
        REG_EPSILON:  cfg_q.epsilon  <= cfg_data_i[EPS_W-1:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  assign cmd_item = {opcode_i, min_x_i, max_x_i, min_y_i, max_y_i, print_z_i};

  phcc_front #(
    .ITEM_W(ITEM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (cmd_item),
    .busy_o      (busy_o),
    .item_valid_o(q_valid),
    .item_o      (q_item),
    .item_pop_i  (q_pop)
  );

  phcc_back #(
    .MAX_ISLANDS(MAX_ISLANDS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .cfg_i       (cfg_q),
    .done_o      (done_o),
    .plan_clear_o(plan_clear_o),
    .hit_o       (hit_o),
    .full_res_o  (full_res_o)
  );

endmodule
`default_nettype wire

// ===== test/phcc_checker.sv =====
`timescale 1ns / 1ps
module phcc_checker import phcc_pkg::*; #(
  parameter int unsigned MAX_ISLANDS = 256,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] min_x_i,
  input  logic [COORD_BITS-1:0] max_x_i,
  input  logic [COORD_BITS-1:0] min_y_i,
  input  logic [COORD_BITS-1:0] max_y_i,
  input  logic [Z_W-1:0]        print_z_i,
  input  logic                  done_i,
  input  logic                  plan_clear_i,
  input  logic                  hit_i,
  input  logic                  full_res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  end_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic plan_clear;
    logic hit;
    logic full_res;
  } island_status_t;

  cfg_t regs;
  logic signed [COORD_BITS-1:0] lo_x [MAX_ISLANDS];
  logic signed [COORD_BITS-1:0] hi_x [MAX_ISLANDS];
  logic signed [COORD_BITS-1:0] lo_y [MAX_ISLANDS];
  logic signed [COORD_BITS-1:0] hi_y [MAX_ISLANDS];
  logic [Z_W-1:0]               height [MAX_ISLANDS];
  int unsigned                  island_count;
  logic                         plan_failed;

  island_status_t status_q [$];
  island_status_t want;
  int             fails;
  bit             end_seen;

  function automatic logic spans_touch(longint a_lo, longint a_hi, longint b_lo,
                                       longint b_hi, longint clr);
    return (a_hi + clr >= b_lo) && (b_hi + clr >= a_lo);
  endfunction

  // Clears the plan store, or checks one island against it and then appends it if there is room.
  function automatic island_status_t scan_island(input logic op,
                                                 input logic [COORD_BITS-1:0] x0,
                                                 input logic [COORD_BITS-1:0] x1,
                                                 input logic [COORD_BITS-1:0] y0,
                                                 input logic [COORD_BITS-1:0] y1,
                                                 input logic [Z_W-1:0] z);
    longint nx0, nx1, ny0, ny1, dz, clr;
    logic   hit, full;
    island_status_t res;
    nx0 = longint'($signed(x0));
    nx1 = longint'($signed(x1));
    ny0 = longint'($signed(y0));
    ny1 = longint'($signed(y1));
    hit = 1'b0;
    full = 1'b0;
    if (op == OP_CLEAR) begin
      island_count = 0;
      plan_failed = 1'b0;
      res = '{plan_clear: 1'b1, hit: 1'b0, full_res: 1'b0};
      return res;
    end
    for (int i = 0; i < island_count; i++) begin
      dz = longint'(height[i]) - longint'(z);
      if (dz <= longint'(regs.epsilon)) continue;
      clr = (dz < longint'(regs.near_hgt)) ? longint'(regs.near_clr) : longint'(regs.radius);
      if (spans_touch(ny0, ny1, longint'(lo_y[i]), longint'(hi_y[i]), clr) &&
          (dz >= longint'(regs.gantry) ||
           spans_touch(nx0, nx1, longint'(lo_x[i]), longint'(hi_x[i]), clr)))
        hit = 1'b1;
    end
    if (island_count < MAX_ISLANDS) begin
      lo_x[island_count] = x0;
      hi_x[island_count] = x1;
      lo_y[island_count] = y0;
      hi_y[island_count] = y1;
      height[island_count] = z;
      island_count++;
    end else begin
      full = 1'b1;
    end
    if (hit || full) plan_failed = 1'b1;
    res = '{plan_clear: !plan_failed, hit: hit, full_res: full};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{radius: RADIUS_RST, gantry: GANTRY_RST, near_clr: NEAR_CLR_RST,
               near_hgt: NEAR_HGT_RST, epsilon: EPSILON_RST};
      island_count = 0;
      plan_failed = 1'b0;
      status_q.delete();
      fails = 0;
      end_seen = 1'b0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (status_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          want = status_q.pop_front();
          if (want.plan_clear !== plan_clear_i) begin
            $error("plan_clear: expected %0b, actual %0b", want.plan_clear, plan_clear_i);
            fails++;
          end
          if (want.hit !== hit_i) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit_i);
            fails++;
          end
          if (want.full_res !== full_res_i) begin
            $error("full_res: expected %0b, actual %0b", want.full_res, full_res_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i)
        status_q = {status_q, scan_island(opcode_i, min_x_i, max_x_i, min_y_i, max_y_i,
                                          print_z_i)};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS:   regs.radius = cfg_data_i;
          REG_GANTRY:   regs.gantry = cfg_data_i;
          REG_NEAR_CLR: regs.near_clr = cfg_data_i;
          REG_NEAR_HGT: regs.near_hgt = cfg_data_i;
          REG_EPSILON:  regs.epsilon = cfg_data_i[EPS_W-1:0];
          default: ;
        endcase
      end
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (status_q.size() != 0) begin
          $error("%0d transactions never got a result", status_q.size());
          fails += status_q.size();
        end
      end
      pending_o <= status_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== test/print_head_collision_check_tb.sv =====
`timescale 1ns / 1ps
module print_head_collision_check_tb;
  import phcc_pkg::*;

  localparam int unsigned MAX_ISLANDS = 256;
  localparam int unsigned COORD_BITS = 32;
  localparam int          WATCHDOG_LIMIT = 4096;
  localparam int          N_PHASES = 10;
  localparam longint      COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
  localparam longint      COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint      Z_MAX = (longint'(1) << Z_W) - 1;
  localparam longint      BED = 250_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  opcode_i;
  logic [COORD_BITS-1:0] min_x_i;
  logic [COORD_BITS-1:0] max_x_i;
  logic [COORD_BITS-1:0] min_y_i;
  logic [COORD_BITS-1:0] max_y_i;
  logic [Z_W-1:0]        print_z_i;
  logic                  done_o;
  logic                  plan_clear_o;
  logic                  hit_o;
  logic                  full_res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  end_check;
  int                    pending_count;
  int                    fail_count;

  int     n_sent;
  int     quiet_cycles;
  bit     idle_on;
  // register values as currently loaded, used to aim islands at the thresholds
  longint cur_radius, cur_gantry, cur_near_clr, cur_near_hgt, cur_eps;
  // last island of the current object
  longint bx0, bx1, by0, by1, bz;

  print_head_collision_check #(
    .MAX_ISLANDS(MAX_ISLANDS),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .min_x_i     (min_x_i),
    .max_x_i     (max_x_i),
    .min_y_i     (min_y_i),
    .max_y_i     (max_y_i),
    .print_z_i   (print_z_i),
    .done_o      (done_o),
    .plan_clear_o(plan_clear_o),
    .hit_o       (hit_o),
    .full_res_o  (full_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  phcc_checker #(
    .MAX_ISLANDS(MAX_ISLANDS),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .opcode_i    (opcode_i),
    .min_x_i     (min_x_i),
    .max_x_i     (max_x_i),
    .min_y_i     (min_y_i),
    .max_y_i     (max_y_i),
    .print_z_i   (print_z_i),
    .done_i      (done_o),
    .plan_clear_i(plan_clear_o),
    .hit_i       (hit_o),
    .full_res_i  (full_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .end_i       (end_check),
    .pending_o   (pending_count),
    .fail_count_o(fail_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint clamp_z(longint v);
    if (v < 0) return 0;
    if (v > Z_MAX) return Z_MAX;
    return v;
  endfunction

  task automatic send(input logic op, input longint x0, input longint x1,
                      input longint y0, input longint y1, input longint z);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    min_x_i <= x0[COORD_BITS-1:0];
    max_x_i <= x1[COORD_BITS-1:0];
    min_y_i <= y0[COORD_BITS-1:0];
    max_y_i <= y1[COORD_BITS-1:0];
    print_z_i <= z[Z_W-1:0];
    do @(posedge clk_i); while (busy_o);
    n_sent++;
  endtask

  // pending_count is a registered copy of the checker queue size, hence the first edge
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // writes every index, the unused ones with junk that must be ignored
  task automatic load_regs(input longint r, input longint g, input longint nc,
                           input longint nh, input longint e);
    logic [CFG_W-1:0] vals [1 << CFG_IDX_W];
    foreach (vals[k]) vals[k] = CFG_W'($urandom);
    vals[REG_RADIUS] = r[CFG_W-1:0];
    vals[REG_GANTRY] = g[CFG_W-1:0];
    vals[REG_NEAR_CLR] = nc[CFG_W-1:0];
    vals[REG_NEAR_HGT] = nh[CFG_W-1:0];
    vals[REG_EPSILON] = e[CFG_W-1:0];
    for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= k[CFG_IDX_W-1:0];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_radius = longint'(vals[REG_RADIUS]);
    cur_gantry = longint'(vals[REG_GANTRY]);
    cur_near_clr = longint'(vals[REG_NEAR_CLR]);
    cur_near_hgt = longint'(vals[REG_NEAR_HGT]);
    cur_eps = longint'(vals[REG_EPSILON][EPS_W-1:0]);
  endtask

  // One plan: a clear, then mostly objects printed one after another, layer by layer, with random islands,
  // inverted boxes and clears mixed in. flood keeps adding without clears so the store overflows.
  task automatic run_plan(input int n_items, input bit flood);
    int     kind;
    longint z, w, h, g, dz, nx0, nx1, ny0, ny1;
    send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    bx0 = $urandom_range(0, BED);
    bx1 = bx0 + $urandom_range(1, 40_000_000);
    by0 = $urandom_range(0, BED);
    by1 = by0 + $urandom_range(1, 40_000_000);
    bz = $urandom_range(0, 40_000_000);
    send(OP_ADD, bx0, bx1, by0, by1, bz);
    repeat (n_items - 1) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        bz = clamp_z(bz + longint'($urandom_range(0, 3_000_000)));
        send(OP_ADD, bx0, bx1, by0, by1, bz);
      end else if (kind < 82) begin
        // next object usually starts lower; aim dz and the gap at the decision edges
        case ($urandom_range(0, 8))
          0:       dz = cur_eps;
          1:       dz = cur_eps + 1;
          2:       dz = cur_near_hgt - 1;
          3:       dz = cur_near_hgt;
          4:       dz = cur_gantry - 1;
          5:       dz = cur_gantry;
          6:       dz = cur_gantry + 1;
          7:       dz = longint'($urandom_range(0, 60_000_000));
          default: dz = -longint'($urandom_range(0, 5_000_000));
        endcase
        z = clamp_z(bz - dz);
        case ($urandom_range(0, 4))
          0:       g = cur_radius;
          1:       g = cur_radius + 1;
          2:       g = cur_near_clr;
          3:       g = cur_near_clr + 1;
          default: g = longint'($urandom_range(0, 90_000_000));
        endcase
        w = $urandom_range(1, 40_000_000);
        h = $urandom_range(1, 40_000_000);
        if ($urandom_range(0, 3) == 0) begin
          nx0 = $urandom_range(0, BED);
          ny0 = $urandom_range(0, BED);
          nx1 = nx0 + w;
          ny1 = ny0 + h;
        end else if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            nx0 = bx1 + g;
            nx1 = nx0 + w;
          end else begin
            nx1 = bx0 - g;
            nx0 = nx1 - w;
          end
          ny0 = by0 + longint'($urandom_range(0, 20_000_000)) - 10_000_000;
          ny1 = ny0 + h;
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            ny0 = by1 + g;
            ny1 = ny0 + h;
          end else begin
            ny1 = by0 - g;
            ny0 = ny1 - h;
          end
          nx0 = bx0 + longint'($urandom_range(0, 20_000_000)) - 10_000_000;
          nx1 = nx0 + w;
        end
        bx0 = nx0;
        bx1 = nx1;
        by0 = ny0;
        by1 = ny1;
        bz = z;
        send(OP_ADD, bx0, bx1, by0, by1, bz);
      end else if (kind < 92) begin
        send(OP_ADD, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 96 && !flood) begin
        send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // inverted box
        send(OP_ADD, bx1, bx0, by1, by0,
             clamp_z(bz - longint'($urandom_range(0, 30_000_000))));
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = OP_CLEAR;
    min_x_i = '0;
    max_x_i = '0;
    min_y_i = '0;
    max_y_i = '0;
    print_z_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_RADIUS;
    cfg_data_i = '0;
    end_check = 1'b0;
    idle_on = 1'b0;
    n_sent = 0;
    quiet_cycles = 0;
    cur_radius = RADIUS_RST;
    cur_gantry = GANTRY_RST;
    cur_near_clr = NEAR_CLR_RST;
    cur_near_hgt = NEAR_HGT_RST;
    cur_eps = EPSILON_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    send(OP_CLEAR, 0, 0, 0, 0, 0);
    send(OP_ADD, 0, 10_000_000, 0, 10_000_000, 30_000_000);
    send(OP_ADD, 200_000_000, 210_000_000, 0, 10_000_000, 0);  // gantry reach
    send(OP_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, Z_MAX);
    send(OP_ADD, 0, 10_000_000, 0, 10_000_000, 15_000_000);
    send(OP_ADD, 200_000_000, 210_000_000, 0, 10_000_000, 0);  // below gantry, far in X
    send(OP_ADD, 55_000_000, 60_000_000, 0, 10_000_000, 0);    // X gap equals radius
    send(OP_ADD, 0, 10_000_000, 0, 10_000_000, 0);             // checked after failure
    send(OP_CLEAR, 0, 0, 0, 0, 0);
    send(OP_ADD, 0, 10_000_000, 0, 10_000_000, 1000);
    send(OP_ADD, 0, 10_000_000, 0, 10_000_000, 900);            // dz equals epsilon
    send(OP_ADD, 15_000_001, 20_000_000, 0, 10_000_000, 899);   // near band, gap just over
    send(OP_ADD, 15_000_000, 20_000_000, 0, 10_000_000, 899);   // near band, gap exact
    send(OP_CLEAR, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send(OP_ADD, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, Z_MAX);
    send(OP_ADD, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0);
    send(OP_ADD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send(OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, Z_MAX);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: ;
        1: load_regs(0, 0, 0, 0, 0);
        2: load_regs(Z_MAX, Z_MAX, Z_MAX, Z_MAX, Z_MAX);
        3: load_regs(RADIUS_RST, GANTRY_RST, NEAR_CLR_RST, NEAR_HGT_RST, EPSILON_RST);
        default: begin
          if (phase % 2)
            load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
          else
            load_regs($urandom_range(0, 80_000_000), $urandom_range(0, 40_000_000),
                      $urandom_range(0, 10_000_000), $urandom_range(0, 5_000_000),
                      $urandom_range(0, 200_000));
        end
      endcase
      if (phase == 4 || phase == 7) begin
        idle_on = 1'b1;
        run_plan(MAX_ISLANDS + $urandom_range(1, 4), 1'b1);
      end
      while (n_sent < 20 + 100 * (phase + 1)) begin
        // the final phase runs with no sender gaps
        idle_on = (phase < N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        run_plan($urandom_range(3, 40), 1'b0);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
